FILE: src/lru_key_value_cache_macros.svh
// Assertion shorthands for the cache checker.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define LKVC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lkvc check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define LKVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkvc check failed");

`endif

FILE: src/lkvc_pkg.sv
package lkvc_pkg;

  localparam int FIELD_BITS = 32;
  localparam int CAP_BITS   = 5;

  localparam logic [CAP_BITS-1:0]          CAP_RESET  = 5'd16;
  localparam logic signed [FIELD_BITS-1:0] MISS_VALUE = -32'sd1;
  localparam logic signed [FIELD_BITS-1:0] PUT_VALUE  = 32'sd0;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef struct packed {
    logic                         mode;
    logic signed [FIELD_BITS-1:0] lookup_key;
    logic signed [FIELD_BITS-1:0] store_value;
  } lkvc_req_t;

  typedef struct packed {
    logic                         found;
    logic signed [FIELD_BITS-1:0] read_value;
  } lkvc_rsp_t;

  typedef struct packed {
    logic load_req;
    logic lookup;
    logic commit;
  } lkvc_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_UPDATE
  } lkvc_state_t;

endpackage

FILE: src/lru_key_value_cache.sv
// Channel   Direction  Handshake                  Payload
// cfg       in         cfg_valid / cfg_ready      cfg_data: capacity_in_use
// req       in         req_valid / req_stall      req: mode, lookup_key, store_value
// rsp       out        rsp_valid / rsp_stall      rsp: found, read_value
//
// Each request passes a compare state, matching its key against every slot, then an
// update state for recency ranks, key and value memory. A new request is taken in
// the update state once the response register is free. Reset (rst, synchronous)
// empties the store at once through the valid bits; there is no clearing pass. A
// stalled response is held in the output register while one more request is taken.
module lru_key_value_cache #(
  parameter int ENTRIES   = 16,
  parameter int DATA_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lkvc_pkg::CAP_BITS-1:0] cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  lkvc_pkg::lkvc_req_t           req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output lkvc_pkg::lkvc_rsp_t           rsp
);
  import lkvc_pkg::*;

  lkvc_cmd_t cmd;
  logic      cfg_write;

  // Capacity writes must arrive only while idle; the block does not enforce this and keeps cfg_ready high.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Sequence each request: accept, compare, update and present the response.
  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // Hold keys, values, ranks and the response register.
  lkvc_datapath #(
    .ENTRIES   (ENTRIES),
    .DATA_BITS (DATA_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

endmodule

FILE: src/lkvc_ctrl.sv
module lkvc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output lkvc_pkg::lkvc_cmd_t cmd
);
  import lkvc_pkg::*;

  lkvc_state_t state;
  lkvc_state_t state_next;
  logic        rsp_valid_next;
  logic        commit_ok;
  logic        accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    commit_ok  = (state == ST_UPDATE) && (!rsp_valid || !rsp_stall);
    req_stall  = !((state == ST_IDLE) || commit_ok);
    accept     = req_valid && !req_stall;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_COMPARE;
      end
      ST_COMPARE: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (commit_ok) state_next = accept ? ST_COMPARE : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    priority if (commit_ok) rsp_valid_next = 1'b1;
    else if (!rsp_stall)    rsp_valid_next = 1'b0;
    else                    rsp_valid_next = rsp_valid;
    cmd.load_req = accept;
    cmd.lookup   = (state == ST_COMPARE);
    cmd.commit   = commit_ok;
  end

endmodule

FILE: src/lkvc_datapath.sv
module lkvc_datapath #(
  parameter int ENTRIES   = 16,
  parameter int DATA_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lkvc_pkg::lkvc_cmd_t               cmd,
  input  logic                              cfg_write,
  input  logic [lkvc_pkg::CAP_BITS-1:0]     cfg_data,
  input  lkvc_pkg::lkvc_req_t               req,
  output lkvc_pkg::lkvc_rsp_t               rsp
);
  import lkvc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

  logic [CAP_BITS-1:0]         capacity;
  lkvc_req_t                   req_q;
  logic signed [FIELD_BITS-1:0] slot_key [ENTRIES];
  logic [ENTRIES-1:0]          slot_valid;
  logic [IDX_W-1:0]            rank [ENTRIES];
  logic [CNT_W-1:0]            count;
  logic [DATA_BITS-1:0]        value_mem [ENTRIES];
  logic [DATA_BITS-1:0]        mem_q;

  logic                        hit_q;
  logic                        insert_q;
  logic [IDX_W-1:0]            tgt_q;
  logic [CNT_W-1:0]            touch_rank_q;

  logic [ENTRIES-1:0]          hit_vec;
  logic [ENTRIES-1:0]          victim_vec;
  logic [ENTRIES-1:0]          free_vec;
  logic [IDX_W-1:0]            hit_idx;
  logic [IDX_W-1:0]            victim_idx;
  logic [IDX_W-1:0]            free_idx;
  logic [CNT_W-1:0]            hit_rank;
  logic [CMP_W-1:0]            cap_ext;
  logic [CMP_W-1:0]            eff_cap;
  logic                        full;
  logic                        any_hit;
  logic                        update;
  logic [DATA_BITS-1:0]        wr_data;
  logic signed [FIELD_BITS-1:0] rd_value;

  // Parallel key match, victim pick by rank, lowest free slot.
  always_comb begin
    hit_idx    = '0;
    victim_idx = '0;
    free_idx   = '0;
    hit_rank   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]    = slot_valid[i] && (slot_key[i] == req_q.lookup_key);
      victim_vec[i] = slot_valid[i] && (CNT_W'(rank[i]) == count - CNT_W'(1));
    end
    free_vec = ~slot_valid & (slot_valid + ENTRIES'(1));
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_idx  = hit_idx | IDX_W'(i);
        hit_rank = hit_rank | CNT_W'(rank[i]);
      end
      if (victim_vec[i]) victim_idx = victim_idx | IDX_W'(i);
      if (free_vec[i])   free_idx   = free_idx | IDX_W'(i);
    end
    any_hit = |hit_vec;
    cap_ext = CMP_W'(capacity);
    priority if (cap_ext == '0)                eff_cap = CMP_W'(1);
    else if (cap_ext > CMP_W'(ENTRIES))        eff_cap = CMP_W'(ENTRIES);
    else                                       eff_cap = cap_ext;
    full    = (CMP_W'(count) >= eff_cap);
    update  = hit_q || (req_q.mode == MODE_PUT);
    wr_data = DATA_BITS'($unsigned(req_q.store_value));
    rd_value = FIELD_BITS'($signed(mem_q));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) req_q <= req;
    if (cmd.lookup) begin
      hit_q <= any_hit;
      priority if (any_hit) begin
        tgt_q        <= hit_idx;
        touch_rank_q <= hit_rank;
        insert_q     <= 1'b0;
      end else if (full) begin
        tgt_q        <= victim_idx;
        touch_rank_q <= count - CNT_W'(1);
        insert_q     <= 1'b0;
      end else begin
        tgt_q        <= free_idx;
        touch_rank_q <= count;
        insert_q     <= (req_q.mode == MODE_PUT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) mem_q <= value_mem[hit_idx];
    if (cmd.commit && (req_q.mode == MODE_PUT)) value_mem[tgt_q] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !hit_q && (req_q.mode == MODE_PUT)) begin
      slot_key[tgt_q] <= req_q.lookup_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      count      <= '0;
      for (int i = 0; i < ENTRIES; i++) rank[i] <= '0;
    end else if (cmd.commit) begin
      if (insert_q) begin
        slot_valid[tgt_q] <= 1'b1;
        count             <= count + CNT_W'(1);
      end
      if (update) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == tgt_q) begin
            rank[i] <= '0;
          end else if (slot_valid[i] && (CNT_W'(rank[i]) < touch_rank_q)) begin
            rank[i] <= rank[i] + IDX_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.found <= hit_q;
      priority if (req_q.mode == MODE_PUT) rsp.read_value <= PUT_VALUE;
      else if (hit_q)                      rsp.read_value <= rd_value;
      else                                 rsp.read_value <= MISS_VALUE;
    end
  end

endmodule

FILE: src/lkvc_checker.sv
`include "lru_key_value_cache_macros.svh"

module lkvc_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input lkvc_pkg::lkvc_rsp_t rsp
);
  import lkvc_pkg::*;

  `LKVC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
  `LKVC_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall)
  `LKVC_ASSERT_NOW(a_miss_value, rsp_valid && !rsp.found, rsp.read_value == MISS_VALUE || rsp.read_value == PUT_VALUE)

endmodule

bind lru_key_value_cache lkvc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

FILE: dv/tb_top.sv
module tb_top;
  import lkvc_pkg::*;

  localparam int SLOTS = 16;

  // Clock and synchronous reset. Every block input starts at a known value.
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CAP_BITS-1:0] cfg_data  = '0;
  logic                req_valid = 1'b0;
  logic                req_stall;
  lkvc_req_t           req       = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  lkvc_rsp_t           rsp;

  always #5 clk = ~clk;

  lru_key_value_cache #(
    .ENTRIES   (SLOTS),
    .DATA_BITS (FIELD_BITS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Idle percentages for each side, and the length of a forced response hold-off.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;

  // Key neighborhood for the current random segment, so that hits and evictions happen.
  logic [FIELD_BITS-1:0] key_base = '0;

  int fail_count = 0;

  // Shadow copy of the cache contents: keys, data, occupancy and recency per slot.
  logic [FIELD_BITS-1:0] cache_keys [SLOTS];
  logic [FIELD_BITS-1:0] cache_data [SLOTS];
  logic                  cache_used [SLOTS];
  int                    age_rank   [SLOTS];
  int                    held_count = 0;
  logic [CAP_BITS-1:0]   cap_setting = CAP_RESET;

  // Responses owed by the block, oldest first.
  lkvc_rsp_t pending_rsp[$];

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      cache_keys[i] = '0;
      cache_data[i] = '0;
      cache_used[i] = 1'b0;
      age_rank[i]   = 0;
    end
  end

  // Clamp the register to the range the block can actually hold.
  function automatic int eff_capacity();
    int lim;
    lim = cap_setting;
    if (lim < 1) lim = 1;
    if (lim > SLOTS) lim = SLOTS;
    return lim;
  endfunction

  // Make slot s the most recent; live slots that were more recent age by one.
  function automatic void promote(int s);
    int r;
    r = age_rank[s];
    for (int i = 0; i < SLOTS; i++)
      if (cache_used[i] && i != s && age_rank[i] < r) age_rank[i]++;
    age_rank[s] = 0;
  endfunction

  // Apply one request to the shadow cache and return the response it owes.
  function automatic lkvc_rsp_t predict_access(lkvc_req_t r);
    lkvc_rsp_t o;
    logic      hit;
    int        s;
    int        victim;
    int        oldest;
    hit = 1'b0;
    s   = 0;
    for (int i = 0; i < SLOTS; i++)
      if (cache_used[i] && cache_keys[i] == r.lookup_key) begin
        hit = 1'b1;
        s   = i;
      end
    o.found = hit;

    if (r.mode == MODE_GET) begin
      o.read_value = hit ? cache_data[s] : MISS_VALUE;
      if (hit) promote(s);
      return o;
    end

    o.read_value = PUT_VALUE;
    if (hit) begin
      cache_data[s] = r.store_value;
      promote(s);
      return o;
    end

    // Full (or over a lowered capacity): overwrite the least recent entry in place.
    if (held_count >= eff_capacity() && held_count > 0) begin
      victim = -1;
      oldest = -1;
      for (int i = 0; i < SLOTS; i++)
        if (cache_used[i] && age_rank[i] > oldest) begin
          victim = i;
          oldest = age_rank[i];
        end
      cache_keys[victim] = r.lookup_key;
      cache_data[victim] = r.store_value;
      promote(victim);
      return o;
    end

    // Otherwise fill the lowest free slot as the newest entry.
    for (int i = 0; i < SLOTS; i++)
      if (!cache_used[i]) begin
        for (int j = 0; j < SLOTS; j++)
          if (cache_used[j]) age_rank[j]++;
        cache_used[i] = 1'b1;
        cache_keys[i] = r.lookup_key;
        cache_data[i] = r.store_value;
        age_rank[i]   = 0;
        held_count++;
        break;
      end
    return o;
  endfunction

  function automatic lkvc_req_t make_req(logic m, logic [FIELD_BITS-1:0] k,
                                         logic [FIELD_BITS-1:0] v);
    lkvc_req_t r;
    r.mode        = m;
    r.lookup_key  = k;
    r.store_value = v;
    return r;
  endfunction

  // Mostly keys near the segment base so the working set churns against capacity;
  // the rest are arbitrary keys that almost always miss.
  function automatic lkvc_req_t rand_request();
    int               pool;
    logic [FIELD_BITS-1:0] k;
    pool = eff_capacity() + eff_capacity() / 2 + 2;
    if ($urandom_range(99) < 85) k = key_base + $urandom_range(pool - 1);
    else k = $urandom;
    return make_req($urandom_range(1) ? MODE_PUT : MODE_GET, k, $urandom);
  endfunction

  task automatic flag_error(input string what, input lkvc_rsp_t want, input lkvc_rsp_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] %s: expected found=%0b value=%h, got found=%0b value=%h",
               $time, what, want.found, want.read_value, got.found, got.read_value);
  endtask

  // Drive rsp_stall on the falling edge: a forced hold-off wins, else random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check each accepted response against the oldest owed one, field by field.
  always @(posedge clk) begin
    lkvc_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        flag_error("response with none outstanding", '0, rsp);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.found !== want.found || rsp.read_value !== want.read_value)
          flag_error("response mismatch", want, rsp);
      end
    end
  end

  // Offer one request after a random idle gap; hold it until taken, then predict.
  task automatic send_request(input lkvc_req_t item);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_rsp.push_back(predict_access(item));
  endtask

  // Drop the request line and wait for every owed response, then let the pipe settle.
  task automatic finish_outstanding();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write capacity_in_use only while the block is idle.
  task automatic set_capacity(input logic [CAP_BITS-1:0] value);
    finish_outstanding();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_setting = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Extreme keys and values, get on an empty store, update in place, ignored value on get.
  task automatic test_field_extremes();
    send_request(make_req(MODE_GET, 32'h0000_0000, 32'h0000_0000));
    send_request(make_req(MODE_PUT, 32'h8000_0000, 32'h7fff_ffff));
    send_request(make_req(MODE_PUT, 32'h7fff_ffff, 32'h8000_0000));
    send_request(make_req(MODE_PUT, 32'h0000_0000, 32'hffff_ffff));
    send_request(make_req(MODE_PUT, 32'hffff_ffff, 32'h0000_0000));
    send_request(make_req(MODE_GET, 32'h8000_0000, 32'h0000_0000));
    send_request(make_req(MODE_GET, 32'h7fff_ffff, 32'h0000_0000));
    send_request(make_req(MODE_GET, 32'h0000_0000, 32'h0000_0000));
    send_request(make_req(MODE_GET, 32'hffff_ffff, 32'h0000_0000));
    send_request(make_req(MODE_PUT, 32'h0000_0000, 32'h1234_5678));
    send_request(make_req(MODE_GET, 32'h0000_0000, 32'hffff_ffff));
    send_request(make_req(MODE_GET, 32'h0000_0001, 32'hffff_ffff));
    send_request(make_req(MODE_GET, 32'h0000_0001, 32'h0000_0000));
  endtask

  // Capacity zero acts as one, and it sits below the entries already held:
  // each put miss must replace the least recent entry in place.
  task automatic test_capacity_zero();
    set_capacity(5'd0);
    send_request(make_req(MODE_PUT, 32'd10, 32'd100));
    send_request(make_req(MODE_PUT, 32'd20, 32'd200));
    send_request(make_req(MODE_GET, 32'd10, 32'd0));
    send_request(make_req(MODE_GET, 32'd20, 32'd0));
  endtask

  // Random get/put churn over a small key pool, stepping through idle mixes and
  // capacity settings, the clamped ones (0, 17, 31) among them.
  task automatic test_random_traffic();
    logic [CAP_BITS-1:0] caps [9];
    caps = '{5'd16, 5'd31, 5'd3, 5'd0, 5'd17, 5'd1, 5'd8, 5'd2, 5'd16};
    for (int seg = 0; seg < 9; seg++) begin
      set_capacity(caps[seg]);
      case (seg / 3)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      key_base = $urandom;
      repeat (64) send_request(rand_request());
    end
  endtask

  // Hold the response side for a long stretch while requests keep coming,
  // so the block fills up and must stall its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_left = 150;
    repeat (30) send_request(rand_request());
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_capacity_zero();
    test_random_traffic();
    test_backpressure();

    finish_outstanding();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Abort a hung run well past the slowest legitimate finish.
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/lkvc_pkg.sv
src/lkvc_ctrl.sv
src/lkvc_datapath.sv
src/lru_key_value_cache.sv
src/lkvc_checker.sv
dv/tb_top.sv
